// ===== rtl/khfm_pkg.sv =====
// shared types and constants for the key hold fraction meter
package khfm_pkg;

    localparam int NUM_KEYS  = 256;
    localparam int KEY_AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_W     = 8;
    localparam int TIME_W    = 64;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(FRAC_BITS);

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

endpackage

// ===== rtl/khfm_ram.sv =====
// generic single write port, single read port ram with registered read
module khfm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/key_hold_fraction_meter_core.sv =====
// key hold fraction meter: per-key press tracking and frame hold share query
//
//  channel   dir   tdata fields (low bit up)             tuser       tlast
//  s_*       in    key_index[7:0], time_us[71:8]          operation   -
//  m_*       out   key_is_pressed[0], hold_fraction[17:1] -           -
//
// frame start and press end in dispatch; release runs lo, hi, span and add; a query
// runs dur, lo, span, add, cmp, div and out as needed; one 65-bit add/subtract unit
// does the window clipping, the saturating add and 16 restoring division steps
// reset is asynchronous; pressed flags and held-total valid bits clear at once
// s_tready is high only between words; a query result waits in the output register
// while later words are accepted, and the next result holds until it is taken
module key_hold_fraction_meter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key_index[7:0], time_us[71:8]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // key_is_pressed[0], hold_fraction[17:1], zero[23:18]
);

    localparam int AW = khfm_pkg::KEY_AW;
    localparam int TW = khfm_pkg::TIME_W;
    localparam int FW = khfm_pkg::FRAC_W;
    localparam int FB = khfm_pkg::FRAC_BITS;
    localparam int CW = khfm_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DUR,
        S_LO,
        S_HI,
        S_SPAN,
        S_ADD,
        S_CMP,
        S_DIV,
        S_OUT
    } state_t;

    state_t                       state_reg;
    khfm_pkg::op_t                op_reg;
    logic [khfm_pkg::KEY_W-1:0]   key_reg;
    logic [TW-1:0]                t_reg;
    logic [TW-1:0]                prev_reg;
    logic [TW-1:0]                cur_reg;
    logic [TW-1:0]                lo_reg;
    logic [TW-1:0]                hi_reg;
    logic [TW-1:0]                span_reg;
    logic [TW-1:0]                acc_reg;
    logic [TW-1:0]                dur_reg;
    logic [TW-1:0]                rem_reg;
    logic [FB-1:0]                quo_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         down_reg;
    logic [FW-1:0]                frac_reg;
    logic [khfm_pkg::NUM_KEYS-1:0] pressed_reg;
    logic [khfm_pkg::NUM_KEYS-1:0] tot_valid_reg;
    logic                         out_valid_reg;
    logic                         out_pressed_reg;
    logic [FW-1:0]                out_frac_reg;

    logic [AW-1:0]  key_addr;
    logic [AW-1:0]  rd_addr;
    logic           key_ok;
    logic           key_down;
    logic [TW-1:0]  stamp_rdata;
    logic [TW-1:0]  tot_rdata;
    logic [TW-1:0]  total_cur;
    logic           stamp_we;
    logic           tot_we;
    logic [TW-1:0]  tot_wdata;

    // shared add/subtract unit; on subtract the top bit is "a >= b"
    logic [TW-1:0]  alu_a;
    logic [TW-1:0]  alu_b;
    logic           alu_add;
    logic [TW:0]    alu_res;
    logic [TW-1:0]  rem_shift;
    logic           div_take;
    logic [TW-1:0]  sat_sum;

    assign key_addr  = AW'(key_reg);
    assign rd_addr   = (state_reg == S_IDLE) ? AW'(s_tdata[7:0]) : key_addr;
    assign key_ok    = (32'(key_reg) < 32'(khfm_pkg::NUM_KEYS));
    assign key_down  = key_ok && pressed_reg[key_addr];
    assign total_cur = tot_valid_reg[key_addr] ? tot_rdata : '0;
    assign rem_shift = {rem_reg[TW-2:0], 1'b0};

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_add = 1'b0;
        case (state_reg)
            S_DUR:
            begin
                alu_a = cur_reg;
                alu_b = prev_reg;
            end
            S_LO:
            begin
                alu_a = stamp_rdata;
                alu_b = prev_reg;
            end
            S_HI:
            begin
                alu_a = t_reg;
                alu_b = cur_reg;
            end
            S_SPAN:
            begin
                alu_a = hi_reg;
                alu_b = lo_reg;
            end
            S_ADD:
            begin
                alu_a   = total_cur;
                alu_b   = span_reg;
                alu_add = 1'b1;
            end
            S_CMP:
            begin
                alu_a = acc_reg;
                alu_b = dur_reg;
            end
            S_DIV:
            begin
                alu_a = rem_shift;
                alu_b = dur_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res  = {1'b0, alu_a} + {1'b0, (alu_add ? alu_b : ~alu_b)}
                      + {{TW{1'b0}}, ~alu_add};
    assign sat_sum  = alu_res[TW] ? '1 : alu_res[TW-1:0];
    // shifted-out top bit means the partial remainder already exceeds the divisor
    assign div_take = rem_reg[TW-1] | alu_res[TW];

    assign stamp_we  = (state_reg == S_DISPATCH) && (op_reg == khfm_pkg::OP_PRESS)
                       && key_ok && !pressed_reg[key_addr];
    assign tot_we    = (state_reg == S_ADD) && (op_reg == khfm_pkg::OP_RELEASE);
    assign tot_wdata = sat_sum;

    khfm_ram #(
        .WIDTH (TW),
        .DEPTH (khfm_pkg::NUM_KEYS)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (stamp_we),
        .wr_addr (key_addr),
        .wr_data (t_reg),
        .rd_addr (rd_addr),
        .rd_data (stamp_rdata)
    );

    khfm_ram #(
        .WIDTH (TW),
        .DEPTH (khfm_pkg::NUM_KEYS)
    ) u_total_ram (
        .clk     (clk),
        .wr_en   (tot_we),
        .wr_addr (key_addr),
        .wr_data (tot_wdata),
        .rd_addr (rd_addr),
        .rd_data (tot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pressed_reg   <= '0;
            tot_valid_reg <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_OUT the output register is handled by that state alone
            if (out_valid_reg && m_tready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= khfm_pkg::op_t'(s_tuser);
                        key_reg   <= s_tdata[7:0];
                        t_reg     <= s_tdata[71:8];
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    case (op_reg)
                        khfm_pkg::OP_FRAME:
                        begin
                            prev_reg      <= cur_reg;
                            cur_reg       <= t_reg;
                            tot_valid_reg <= '0;
                            state_reg     <= S_IDLE;
                        end
                        khfm_pkg::OP_PRESS:
                        begin
                            if (stamp_we)
                            begin
                                pressed_reg[key_addr] <= 1'b1;
                            end
                            state_reg <= S_IDLE;
                        end
                        khfm_pkg::OP_RELEASE:
                        begin
                            state_reg <= key_down ? S_LO : S_IDLE;
                        end
                        default:
                        begin
                            down_reg <= key_down;
                            frac_reg <= '0;
                            state_reg <= key_ok ? S_DUR : S_OUT;
                        end
                    endcase
                end
                S_DUR:
                begin
                    dur_reg <= alu_res[TW-1:0];
                    hi_reg  <= cur_reg;
                    acc_reg <= total_cur;
                    if (!alu_res[TW] || (alu_res[TW-1:0] == '0))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= down_reg ? S_LO : S_CMP;
                    end
                end
                S_LO:
                begin
                    lo_reg    <= alu_res[TW] ? stamp_rdata : prev_reg;
                    state_reg <= (op_reg == khfm_pkg::OP_RELEASE) ? S_HI : S_SPAN;
                end
                S_HI:
                begin
                    hi_reg    <= alu_res[TW] ? cur_reg : t_reg;
                    state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    span_reg  <= alu_res[TW] ? alu_res[TW-1:0] : '0;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    acc_reg <= sat_sum;
                    if (op_reg == khfm_pkg::OP_RELEASE)
                    begin
                        pressed_reg[key_addr]   <= 1'b0;
                        tot_valid_reg[key_addr] <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    rem_reg <= acc_reg;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    if (alu_res[TW])
                    begin
                        frac_reg  <= khfm_pkg::FRAC_ONE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= div_take ? alu_res[TW-1:0] : rem_shift;
                    quo_reg <= {quo_reg[FB-2:0], div_take};
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(FB - 1))
                    begin
                        frac_reg  <= {1'b0, quo_reg[FB-2:0], div_take};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_pressed_reg <= down_reg;
                        out_frac_reg    <= frac_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_frac_reg, out_pressed_reg};

    // share never exceeds the whole frame
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:1] <= khfm_pkg::FRAC_ONE))
        else $error("hold fraction above one");

    // restoring division keeps the partial remainder below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < dur_reg))
        else $error("division remainder not below frame length");

    // division only starts on a nonempty frame
    a_dur_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (dur_reg != '0))
        else $error("fraction computed on an empty frame");

    // a finished query never overwrites a word still waiting downstream
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !m_tready) |=> (state_reg == S_OUT))
        else $error("result dropped while output stalled");

    // an accepted word closes the input until it is done
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input open while a word is in work");

endmodule
